// File: src/qat_pkg.sv
package qat_pkg;

    // result kinds
    localparam logic [1:0] KIND_BYTE = 2'd0;
    localparam logic [1:0] KIND_TEND = 2'd1;
    localparam logic [1:0] KIND_OK   = 2'd2;
    localparam logic [1:0] KIND_ERR  = 2'd3;

    // request types
    localparam logic REQ_BYTE = 1'b0;
    localparam logic REQ_EOL  = 1'b1;

    localparam int MaxResults = 3;

    // characters
    localparam logic [7:0] CH_NUL    = 8'h00;
    localparam logic [7:0] CH_BEL    = 8'h07;
    localparam logic [7:0] CH_BS     = 8'h08;
    localparam logic [7:0] CH_TAB    = 8'h09;
    localparam logic [7:0] CH_LF     = 8'h0A;
    localparam logic [7:0] CH_VT     = 8'h0B;
    localparam logic [7:0] CH_FF     = 8'h0C;
    localparam logic [7:0] CH_CR     = 8'h0D;
    localparam logic [7:0] CH_SPACE  = 8'h20;
    localparam logic [7:0] CH_DQUOTE = 8'h22;
    localparam logic [7:0] CH_SQUOTE = 8'h27;
    localparam logic [7:0] CH_ZERO   = 8'h30;
    localparam logic [7:0] CH_NINE   = 8'h39;
    localparam logic [7:0] CH_UP_A   = 8'h41;
    localparam logic [7:0] CH_UP_F   = 8'h46;
    localparam logic [7:0] CH_BSLASH = 8'h5C;
    localparam logic [7:0] CH_A      = 8'h61;
    localparam logic [7:0] CH_B      = 8'h62;
    localparam logic [7:0] CH_F      = 8'h66;
    localparam logic [7:0] CH_N      = 8'h6E;
    localparam logic [7:0] CH_R      = 8'h72;
    localparam logic [7:0] CH_T      = 8'h74;
    localparam logic [7:0] CH_X      = 8'h78;

    typedef enum logic [3:0] {
        MODE_BETWEEN = 4'd0,
        MODE_WORD    = 4'd1,
        MODE_DQ      = 4'd2,
        MODE_DQ_BS   = 4'd3,
        MODE_DQ_BX   = 4'd4,
        MODE_DQ_BXH  = 4'd5,
        MODE_CLOSED  = 4'd6,
        MODE_SQ      = 4'd7,
        MODE_SQ_BS   = 4'd8,
        MODE_ERROR   = 4'd9
    } qat_mode_t;

    typedef struct packed {
        logic       req_type;
        logic [7:0] char_in;
    } qat_in_t;

    typedef struct packed {
        logic [1:0]  out_kind;
        logic [7:0]  char_out;
        logic [15:0] arg_count;
        logic        last_out;
    } qat_out_t;

    typedef struct packed {
        qat_mode_t   mode;
        logic [7:0]  held;
        logic [15:0] count;
    } qat_state_t;

    // results caused by one item, oldest in slot 0
    typedef struct packed {
        qat_out_t [MaxResults-1:0] item;
        logic [1:0]                num;
    } qat_res_set_t;

    function automatic logic is_blank(input logic [7:0] c);
        return c == CH_SPACE || c == CH_TAB || c == CH_LF || c == CH_VT ||
               c == CH_FF || c == CH_CR;
    endfunction

    function automatic logic is_word_end(input logic [7:0] c);
        return c == CH_SPACE || c == CH_LF || c == CH_CR || c == CH_TAB;
    endfunction

    function automatic logic is_hex(input logic [7:0] c);
        return (c >= CH_ZERO && c <= CH_NINE) || (c >= CH_A && c <= CH_F) ||
               (c >= CH_UP_A && c <= CH_UP_F);
    endfunction

    // letters have bit 6 set and low nibble 1..6
    function automatic logic [3:0] hex_val(input logic [7:0] c);
        return c[6] ? c[3:0] + 4'd9 : c[3:0];
    endfunction

    function automatic logic [15:0] sat_inc(input logic [15:0] v);
        return (v == 16'hFFFF) ? v : v + 16'd1;
    endfunction

    function automatic logic [7:0] esc_map(input logic [7:0] c);
        logic [7:0] m;
        m = c;
        if (c == CH_N) m = CH_LF;
        else if (c == CH_R) m = CH_CR;
        else if (c == CH_T) m = CH_TAB;
        else if (c == CH_B) m = CH_BS;
        else if (c == CH_A) m = CH_BEL;
        return m;
    endfunction

    function automatic qat_out_t mk_out(input logic [1:0] kind, input logic [7:0] ch,
                                        input logic [15:0] cnt);
        qat_out_t r;
        r.out_kind  = kind;
        r.char_out  = ch;
        r.arg_count = cnt;
        r.last_out  = 1'b0;
        return r;
    endfunction

endpackage

// File: src/qat_step.sv
module qat_step import qat_pkg::*; (
    input  qat_in_t      item,
    input  qat_state_t   cur,
    output qat_state_t   nxt,
    output qat_res_set_t rset
);

    logic [7:0] c;
    logic       is_byte;

    assign c       = item.char_in;
    assign is_byte = (item.req_type == REQ_BYTE) && (c != CH_NUL);

    function automatic qat_mode_t dq_next(input logic [7:0] ch);
        if (ch == CH_BSLASH) return MODE_DQ_BS;
        else if (ch == CH_DQUOTE) return MODE_CLOSED;
        return MODE_DQ;
    endfunction

    // next state
    always_comb begin
        nxt = cur;
        if (item.req_type == REQ_EOL) begin
            nxt.mode  = MODE_BETWEEN;
            nxt.held  = '0;
            nxt.count = '0;
        end else if (is_byte) begin
            unique case (cur.mode) inside
                MODE_BETWEEN, MODE_WORD: begin
                    if (cur.mode == MODE_BETWEEN && is_blank(c)) begin
                        nxt.mode = MODE_BETWEEN;
                    end else if (is_word_end(c)) begin
                        nxt.mode  = MODE_BETWEEN;
                        nxt.count = sat_inc(cur.count);
                    end else if (c == CH_DQUOTE) begin
                        nxt.mode = MODE_DQ;
                    end else if (c == CH_SQUOTE) begin
                        nxt.mode = MODE_SQ;
                    end else begin
                        nxt.mode = MODE_WORD;
                    end
                end
                MODE_DQ: nxt.mode = dq_next(c);
                MODE_DQ_BS: nxt.mode = (c == CH_X) ? MODE_DQ_BX : MODE_DQ;
                MODE_DQ_BX: begin
                    if (is_hex(c)) begin
                        nxt.held = c;
                        nxt.mode = MODE_DQ_BXH;
                    end else begin
                        nxt.mode = dq_next(c);
                    end
                end
                MODE_DQ_BXH: begin
                    nxt.held = '0;
                    nxt.mode = is_hex(c) ? MODE_DQ : dq_next(c);
                end
                MODE_CLOSED: begin
                    if (is_blank(c)) begin
                        nxt.mode  = MODE_BETWEEN;
                        nxt.count = sat_inc(cur.count);
                    end else begin
                        nxt.mode = MODE_ERROR;
                    end
                end
                MODE_SQ: begin
                    if (c == CH_BSLASH) nxt.mode = MODE_SQ_BS;
                    else if (c == CH_SQUOTE) nxt.mode = MODE_CLOSED;
                end
                // a second backslash stays pending, anything else reopens plain text
                MODE_SQ_BS: nxt.mode = (c == CH_BSLASH) ? MODE_SQ_BS : MODE_SQ;
                default: nxt.mode = cur.mode;
            endcase
        end
    end

    // results
    always_comb begin
        rset = '0;
        if (item.req_type == REQ_EOL) begin
            unique case (cur.mode) inside
                MODE_BETWEEN: begin
                    rset.item[rset.num] = mk_out(KIND_OK, CH_NUL, cur.count);
                    rset.num = rset.num + 2'd1;
                end
                MODE_WORD, MODE_CLOSED: begin
                    rset.item[rset.num] = mk_out(KIND_TEND, CH_NUL, '0);
                    rset.num = rset.num + 2'd1;
                    rset.item[rset.num] = mk_out(KIND_OK, CH_NUL, sat_inc(cur.count));
                    rset.num = rset.num + 2'd1;
                end
                default: begin
                    rset.item[rset.num] = mk_out(KIND_ERR, CH_NUL, '0);
                    rset.num = rset.num + 2'd1;
                end
            endcase
        end else if (is_byte) begin
            unique case (cur.mode) inside
                MODE_BETWEEN, MODE_WORD: begin
                    if (cur.mode == MODE_BETWEEN && is_blank(c)) begin
                        rset.num = '0;
                    end else if (is_word_end(c)) begin
                        rset.item[rset.num] = mk_out(KIND_TEND, CH_NUL, '0);
                        rset.num = rset.num + 2'd1;
                    end else if (c != CH_DQUOTE && c != CH_SQUOTE) begin
                        rset.item[rset.num] = mk_out(KIND_BYTE, c, '0);
                        rset.num = rset.num + 2'd1;
                    end
                end
                MODE_DQ_BS: begin
                    if (c != CH_X) begin
                        rset.item[rset.num] = mk_out(KIND_BYTE, esc_map(c), '0);
                        rset.num = rset.num + 2'd1;
                    end
                end
                MODE_DQ, MODE_DQ_BX, MODE_DQ_BXH: begin
                    if (cur.mode == MODE_DQ_BXH && is_hex(c)) begin
                        rset.item[rset.num] = mk_out(KIND_BYTE,
                            {hex_val(cur.held), hex_val(c)}, '0);
                        rset.num = rset.num + 2'd1;
                    end else if (!(cur.mode == MODE_DQ_BX && is_hex(c))) begin
                        // broken hex escape flushes the literal text first
                        if (cur.mode != MODE_DQ) begin
                            rset.item[rset.num] = mk_out(KIND_BYTE, CH_X, '0);
                            rset.num = rset.num + 2'd1;
                        end
                        if (cur.mode == MODE_DQ_BXH) begin
                            rset.item[rset.num] = mk_out(KIND_BYTE, cur.held, '0);
                            rset.num = rset.num + 2'd1;
                        end
                        if (c != CH_BSLASH && c != CH_DQUOTE) begin
                            rset.item[rset.num] = mk_out(KIND_BYTE, c, '0);
                            rset.num = rset.num + 2'd1;
                        end
                    end
                end
                MODE_CLOSED: begin
                    if (is_blank(c)) begin
                        rset.item[rset.num] = mk_out(KIND_TEND, CH_NUL, '0);
                        rset.num = rset.num + 2'd1;
                    end
                end
                MODE_SQ: begin
                    if (c != CH_BSLASH && c != CH_SQUOTE) begin
                        rset.item[rset.num] = mk_out(KIND_BYTE, c, '0);
                        rset.num = rset.num + 2'd1;
                    end
                end
                MODE_SQ_BS: begin
                    if (c == CH_SQUOTE) begin
                        rset.item[rset.num] = mk_out(KIND_BYTE, CH_SQUOTE, '0);
                        rset.num = rset.num + 2'd1;
                    end else begin
                        rset.item[rset.num] = mk_out(KIND_BYTE, CH_BSLASH, '0);
                        rset.num = rset.num + 2'd1;
                        if (c != CH_BSLASH) begin
                            rset.item[rset.num] = mk_out(KIND_BYTE, c, '0);
                            rset.num = rset.num + 2'd1;
                        end
                    end
                end
                default: rset.num = '0;
            endcase
        end
        if (rset.num != 2'd0) begin
            rset.item[rset.num - 2'd1].last_out = 1'b1;
        end
    end

endmodule

// File: src/quoted_argument_tokenizer_core.sv
// channel  | ports                    | payload
// ---------+--------------------------+------------------------------------------
// input    | s_valid, s_ready, s_data | qat_in_t: req_type, char_in
// result   | m_valid, m_ready, m_data | qat_out_t: out_kind, char_out, arg_count,
//          |                          |           last_out
//
// one item per cycle when each item makes at most one result and m_ready is high;
// an item that makes more than one result holds the input while the three-slot
// result buffer drains; the next item is taken in the same cycle as the last
// buffered result transfers; results appear in the cycle after the input transfer
// reset (aresetn low, synchronous) empties the result buffer and returns the scanner
// to between-arguments with a zero argument count
module quoted_argument_tokenizer_core import qat_pkg::*; (
    input  logic     aclk,
    input  logic     aresetn,
    input  logic     s_valid,
    output logic     s_ready,
    input  qat_in_t  s_data,
    output logic     m_valid,
    input  logic     m_ready,
    output qat_out_t m_data
);

    qat_state_t                state_reg;
    qat_state_t                state_next;
    qat_res_set_t              rset;
    qat_out_t [MaxResults-1:0] buf_reg;
    logic [1:0]                cnt_reg;
    logic                      s_xfer;
    logic                      m_xfer;

    qat_step u_step (
        .item (s_data),
        .cur  (state_reg),
        .nxt  (state_next),
        .rset (rset)
    );

    assign m_valid = (cnt_reg != 2'd0);
    assign m_data  = buf_reg[0];
    assign m_xfer  = m_valid && m_ready;
    assign s_ready = (cnt_reg == 2'd0) || (cnt_reg == 2'd1 && m_ready);
    assign s_xfer  = s_valid && s_ready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg.mode  <= MODE_BETWEEN;
            state_reg.held  <= '0;
            state_reg.count <= '0;
            cnt_reg         <= '0;
        end else begin
            if (s_xfer) begin
                state_reg <= state_next;
                cnt_reg   <= rset.num;
            end else if (m_xfer) begin
                cnt_reg <= cnt_reg - 2'd1;
            end
        end
    end

    // buffer is empty or draining its last entry whenever a new item transfers
    always_ff @(posedge aclk) begin
        if (s_xfer) begin
            buf_reg <= rset.item;
        end else if (m_xfer) begin
            buf_reg[0] <= buf_reg[1];
            buf_reg[1] <= buf_reg[2];
        end
    end

`ifndef SYNTH
    a_eol_gives_result: assert property (@(posedge aclk) disable iff (!aresetn)
        s_xfer && s_data.req_type == REQ_EOL |=> m_valid)
        else $error("end of line transfer produced no result");

    a_eol_clears_state: assert property (@(posedge aclk) disable iff (!aresetn)
        s_xfer && s_data.req_type == REQ_EOL |=>
            state_reg.mode == MODE_BETWEEN && state_reg.count == 16'd0)
        else $error("scanner state not cleared at end of line");

    a_line_status_last: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && (m_data.out_kind == KIND_OK || m_data.out_kind == KIND_ERR)
            |-> m_data.last_out)
        else $error("line status is not the final result of its item");

    a_char_only_bytes: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_data.out_kind != KIND_BYTE |-> m_data.char_out == CH_NUL)
        else $error("nonzero char_out on a non-byte result");

    a_count_only_ok: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_data.out_kind != KIND_OK |-> m_data.arg_count == 16'd0)
        else $error("nonzero arg_count on a non-status result");
`endif

endmodule

// File: bench/tb.sv
module tb;
    timeunit 1ns;
    timeprecision 1ps;
    import qat_pkg::*;

    localparam int HoldCycles = 200;

    logic     aclk;
    logic     aresetn = 1'b0;
    logic     s_valid = 1'b0;
    logic     s_ready;
    qat_in_t  s_data  = '0;
    logic     m_valid;
    logic     m_ready = 1'b0;
    qat_out_t m_data;

    int idle_pct   = 0;
    int stall_pct  = 0;
    int items_sent = 0;
    int errors     = 0;
    bit hold_req   = 1'b0;

    // splitter state mirrored by the bench
    qat_mode_t   scan_mode_q;
    logic [7:0]  hex_first_q;
    logic [15:0] arg_total_q;
    qat_out_t    item_outs[$];
    qat_out_t    expected_tokens[$];

    quoted_argument_tokenizer_core i_dut (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .s_data  (s_data),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .m_data  (m_data)
    );

    initial begin
        aclk = 1'b0;
        forever #5 aclk = ~aclk;
    end

    initial begin
        #50_000_000;
        $display("FAIL");
        $finish;
    end

    // ---------------------------------------------------------------- splitter model

    function automatic bit skip_blank(input logic [7:0] c);
        return c == CH_SPACE || c == CH_TAB || c == CH_LF || c == CH_VT ||
               c == CH_FF || c == CH_CR;
    endfunction

    function automatic bit ends_word(input logic [7:0] c);
        return c == CH_SPACE || c == CH_TAB || c == CH_LF || c == CH_CR;
    endfunction

    function automatic bit hex_char_ok(input logic [7:0] c);
        return (c >= CH_ZERO && c <= CH_NINE) ||
               ((c | 8'h20) >= CH_A && (c | 8'h20) <= CH_F);
    endfunction

    function automatic logic [3:0] hex_nibble(input logic [7:0] c);
        logic [7:0] v;
        if (c <= CH_NINE) v = c - CH_ZERO;
        else v = (c | 8'h20) - CH_A + 8'd10;
        return v[3:0];
    endfunction

    function automatic void push_out(input logic [1:0] kind, input logic [7:0] ch,
                                     input logic [15:0] cnt);
        qat_out_t r;
        r.out_kind  = kind;
        r.char_out  = ch;
        r.arg_count = cnt;
        r.last_out  = 1'b0;
        item_outs.push_back(r);
    endfunction

    function automatic void finish_arg();
        push_out(KIND_TEND, CH_NUL, 16'd0);
        if (arg_total_q != 16'hFFFF) arg_total_q = arg_total_q + 16'd1;
    endfunction

    function automatic void in_dq(input logic [7:0] c);
        if (c == CH_BSLASH) scan_mode_q = MODE_DQ_BS;
        else if (c == CH_DQUOTE) scan_mode_q = MODE_CLOSED;
        else push_out(KIND_BYTE, c, 16'd0);
    endfunction

    function automatic void in_sq(input logic [7:0] c);
        if (c == CH_BSLASH) scan_mode_q = MODE_SQ_BS;
        else if (c == CH_SQUOTE) scan_mode_q = MODE_CLOSED;
        else push_out(KIND_BYTE, c, 16'd0);
    endfunction

    function automatic void in_word(input logic [7:0] c);
        if (ends_word(c)) begin
            finish_arg();
            scan_mode_q = MODE_BETWEEN;
        end else if (c == CH_DQUOTE) begin
            scan_mode_q = MODE_DQ;
        end else if (c == CH_SQUOTE) begin
            scan_mode_q = MODE_SQ;
        end else begin
            push_out(KIND_BYTE, c, 16'd0);
        end
    endfunction

    function automatic void scan_byte(input logic [7:0] c);
        logic [7:0] m;
        case (scan_mode_q)
            MODE_BETWEEN: begin
                if (!skip_blank(c)) begin
                    scan_mode_q = MODE_WORD;
                    in_word(c);
                end
            end
            MODE_WORD: in_word(c);
            MODE_DQ:   in_dq(c);
            MODE_DQ_BS: begin
                if (c == CH_X) begin
                    scan_mode_q = MODE_DQ_BX;
                end else begin
                    scan_mode_q = MODE_DQ;
                    case (c)
                        CH_N:    m = CH_LF;
                        CH_R:    m = CH_CR;
                        CH_T:    m = CH_TAB;
                        CH_B:    m = CH_BS;
                        CH_A:    m = CH_BEL;
                        default: m = c;
                    endcase
                    push_out(KIND_BYTE, m, 16'd0);
                end
            end
            MODE_DQ_BX: begin
                if (hex_char_ok(c)) begin
                    hex_first_q = c;
                    scan_mode_q = MODE_DQ_BXH;
                end else begin
                    scan_mode_q = MODE_DQ;
                    push_out(KIND_BYTE, CH_X, 16'd0);
                    in_dq(c);
                end
            end
            MODE_DQ_BXH: begin
                scan_mode_q = MODE_DQ;
                if (hex_char_ok(c)) begin
                    push_out(KIND_BYTE, {hex_nibble(hex_first_q), hex_nibble(c)}, 16'd0);
                end else begin
                    // broken escape falls back to literal text
                    push_out(KIND_BYTE, CH_X, 16'd0);
                    push_out(KIND_BYTE, hex_first_q, 16'd0);
                    in_dq(c);
                end
                hex_first_q = 8'd0;
            end
            MODE_CLOSED: begin
                if (skip_blank(c)) begin
                    finish_arg();
                    scan_mode_q = MODE_BETWEEN;
                end else begin
                    scan_mode_q = MODE_ERROR;
                end
            end
            MODE_SQ: in_sq(c);
            MODE_SQ_BS: begin
                if (c == CH_SQUOTE) begin
                    scan_mode_q = MODE_SQ;
                    push_out(KIND_BYTE, CH_SQUOTE, 16'd0);
                end else if (c == CH_BSLASH) begin
                    push_out(KIND_BYTE, CH_BSLASH, 16'd0);
                end else begin
                    scan_mode_q = MODE_SQ;
                    push_out(KIND_BYTE, CH_BSLASH, 16'd0);
                    in_sq(c);
                end
            end
            default: ;
        endcase
    endfunction

    function automatic void end_line();
        if (scan_mode_q == MODE_BETWEEN) begin
            push_out(KIND_OK, CH_NUL, arg_total_q);
        end else if (scan_mode_q == MODE_WORD || scan_mode_q == MODE_CLOSED) begin
            finish_arg();
            push_out(KIND_OK, CH_NUL, arg_total_q);
        end else begin
            push_out(KIND_ERR, CH_NUL, 16'd0);
        end
        scan_mode_q = MODE_BETWEEN;
        hex_first_q = 8'd0;
        arg_total_q = 16'd0;
    endfunction

    function automatic void split_item(input qat_in_t it);
        qat_out_t r;
        item_outs.delete();
        if (it.req_type == REQ_EOL) end_line();
        else if (it.char_in != CH_NUL) scan_byte(it.char_in);
        if (item_outs.size() > 0) begin
            r = item_outs.pop_back();
            r.last_out = 1'b1;
            item_outs.push_back(r);
        end
        foreach (item_outs[i]) expected_tokens.push_back(item_outs[i]);
    endfunction

    // ---------------------------------------------------------------- checking

    task automatic report_mismatch(input string msg);
        errors++;
        if (errors <= 50) $display("mismatch at %0t ns: %s", $time, msg);
    endtask

    always @(posedge aclk) begin
        qat_out_t want;
        if (aresetn && m_valid && m_ready) begin
            if (expected_tokens.size() == 0) begin
                report_mismatch($sformatf("unexpected result %h", m_data));
            end else begin
                want = expected_tokens.pop_front();
                if (m_data.out_kind !== want.out_kind)
                    report_mismatch($sformatf("out_kind got %0d want %0d",
                                              m_data.out_kind, want.out_kind));
                if (m_data.char_out !== want.char_out)
                    report_mismatch($sformatf("char_out got %h want %h",
                                              m_data.char_out, want.char_out));
                if (m_data.arg_count !== want.arg_count)
                    report_mismatch($sformatf("arg_count got %0d want %0d",
                                              m_data.arg_count, want.arg_count));
                if (m_data.last_out !== want.last_out)
                    report_mismatch($sformatf("last_out got %0d want %0d",
                                              m_data.last_out, want.last_out));
            end
        end
    end

    // result side: random stalls, or one long hold-off on request
    initial begin
        forever begin
            @(posedge aclk);
            if (hold_req) begin
                hold_req = 1'b0;
                m_ready <= 1'b0;
                repeat (HoldCycles) @(posedge aclk);
            end else begin
                m_ready <= ($urandom_range(99) >= stall_pct);
            end
        end
    end

    // ---------------------------------------------------------------- stimulus

    task automatic send_item(input logic req, input logic [7:0] ch);
        int gap;
        qat_in_t it;
        gap = 0;
        while (idle_pct > 0 && gap < 20 && $urandom_range(99) < idle_pct) gap++;
        it.req_type = req;
        it.char_in  = ch;
        if (gap > 0) begin
            s_valid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_valid <= 1'b1;
        s_data  <= it;
        do @(posedge aclk); while (!s_ready);
        // transfer done at this edge
        if (!(req == REQ_BYTE && (ch == CH_NUL || scan_mode_q == MODE_ERROR))) items_sent++;
        split_item(it);
    endtask

    task automatic send_text(input string s);
        for (int i = 0; i < s.len(); i++) send_item(REQ_BYTE, s[i]);
    endtask

    function automatic logic [7:0] pick_word_byte();
        logic [7:0] c;
        do c = 8'($urandom_range(255, 1));
        while (ends_word(c) || c == CH_DQUOTE || c == CH_SQUOTE);
        return c;
    endfunction

    function automatic logic [7:0] pick_quoted_byte();
        logic [7:0] c;
        do c = 8'($urandom_range(255, 1));
        while (c == CH_DQUOTE || c == CH_SQUOTE || c == CH_BSLASH);
        return c;
    endfunction

    function automatic logic [7:0] pick_blank();
        logic [7:0] c;
        case ($urandom_range(5))
            0:       c = CH_SPACE;
            1:       c = CH_TAB;
            2:       c = CH_LF;
            3:       c = CH_VT;
            4:       c = CH_FF;
            default: c = CH_CR;
        endcase
        return c;
    endfunction

    function automatic logic [7:0] pick_hex();
        string digits;
        digits = "0123456789abcdefABCDEF";
        return digits[$urandom_range(digits.len() - 1)];
    endfunction

    task automatic send_dq_piece();
        string esc;
        logic [7:0] c;
        esc = "nrtbaq\"\\'";
        case ($urandom_range(5))
            0, 1: send_item(REQ_BYTE, pick_quoted_byte());
            2: begin
                send_item(REQ_BYTE, CH_BSLASH);
                send_item(REQ_BYTE, esc[$urandom_range(esc.len() - 1)]);
            end
            3: begin
                send_item(REQ_BYTE, CH_BSLASH);
                send_item(REQ_BYTE, CH_X);
                send_item(REQ_BYTE, pick_hex());
                send_item(REQ_BYTE, pick_hex());
            end
            4: begin
                // escape cut short after zero or one digit
                send_item(REQ_BYTE, CH_BSLASH);
                send_item(REQ_BYTE, CH_X);
                if ($urandom_range(1)) send_item(REQ_BYTE, pick_hex());
                if ($urandom_range(3) == 0) begin
                    c = CH_BSLASH;
                end else begin
                    do c = pick_quoted_byte(); while (hex_char_ok(c));
                end
                send_item(REQ_BYTE, c);
            end
            default: send_item(REQ_BYTE, pick_blank());
        endcase
    endtask

    task automatic send_sq_piece();
        case ($urandom_range(4))
            0, 1: send_item(REQ_BYTE, pick_quoted_byte());
            2: begin
                send_item(REQ_BYTE, CH_BSLASH);
                send_item(REQ_BYTE, CH_SQUOTE);
            end
            3: begin
                send_item(REQ_BYTE, CH_BSLASH);
                send_item(REQ_BYTE, CH_BSLASH);
            end
            default: begin
                send_item(REQ_BYTE, CH_BSLASH);
                send_item(REQ_BYTE, pick_quoted_byte());
            end
        endcase
    endtask

    task automatic send_part();
        int k;
        int n;
        k = $urandom_range(9);
        if (k <= 3 || k == 9) begin
            n = $urandom_range(4, 1);
            repeat (n) send_item(REQ_BYTE, pick_word_byte());
        end
        if (k == 4 || k == 5 || k == 9) begin
            send_item(REQ_BYTE, CH_DQUOTE);
            n = $urandom_range(3);
            repeat (n) send_dq_piece();
            send_item(REQ_BYTE, CH_DQUOTE);
        end else if (k == 6 || k == 7) begin
            send_item(REQ_BYTE, CH_SQUOTE);
            n = $urandom_range(3);
            repeat (n) send_sq_piece();
            send_item(REQ_BYTE, CH_SQUOTE);
        end else if (k == 8) begin
            send_item(REQ_BYTE, 8'($urandom_range(255)));
        end
    endtask

    task automatic send_random_line();
        int parts;
        int n;
        parts = $urandom_range(4, 1);
        if ($urandom_range(9) == 0) begin
            n = $urandom_range(8, 1);
            repeat (n) send_item(REQ_BYTE, 8'($urandom_range(255)));
        end else begin
            for (int p = 0; p < parts; p++) begin
                // parts mostly blank separated, sometimes glued together
                if (p > 0 ? $urandom_range(9) < 8 : $urandom_range(3) == 0) begin
                    n = $urandom_range(2, 1);
                    repeat (n) send_item(REQ_BYTE, pick_blank());
                end
                send_part();
            end
            if ($urandom_range(7) == 0) send_item(REQ_BYTE, pick_blank());
            if ($urandom_range(15) == 0) send_item(REQ_BYTE, CH_DQUOTE);
        end
        send_item(REQ_EOL, 8'($urandom_range(255)));
    endtask

    // ---------------------------------------------------------------- tests

    task automatic apply_reset();
        scan_mode_q = MODE_BETWEEN;
        hex_first_q = 8'd0;
        arg_total_q = 16'd0;
        repeat (10) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);
    endtask

    task automatic test_line_extremes();
        send_item(REQ_EOL, 8'hFF);
        send_item(REQ_BYTE, 8'h01);
        send_item(REQ_BYTE, 8'hFF);
        send_item(REQ_BYTE, CH_NUL);
        send_item(REQ_BYTE, CH_VT);
        send_item(REQ_BYTE, CH_CR);
        send_item(REQ_EOL, CH_NUL);
    endtask

    task automatic test_escapes();
        send_text("\"\\x4A\\b\" '\\'\\\\z'");
        send_item(REQ_EOL, CH_NUL);
    endtask

    task automatic test_broken_escapes();
        send_text("\"\\xg\\x4z");
        send_item(REQ_EOL, CH_NUL);
    endtask

    task automatic test_quote_errors();
        send_text("\"\\");
        send_item(REQ_EOL, CH_NUL);
        send_text("''x y");
        send_item(REQ_EOL, CH_NUL);
    endtask

    task automatic test_random_phase(input int sender_idle, input int receiver_stall);
        int start;
        idle_pct  = sender_idle;
        stall_pct = receiver_stall;
        start = items_sent;
        while (items_sent - start < 10) send_random_line();
    endtask

    task automatic test_output_holdoff();
        idle_pct  = 0;
        stall_pct = 0;
        hold_req  = 1'b1;
        repeat (16) send_item(REQ_BYTE, pick_word_byte());
        send_item(REQ_EOL, CH_NUL);
    endtask

    task automatic test_drain_pause();
        send_random_line();
        s_valid <= 1'b0;
        while (expected_tokens.size() != 0) @(posedge aclk);
        repeat (3) @(posedge aclk);
        send_random_line();
    endtask

    initial begin
        apply_reset();
        test_line_extremes();
        test_escapes();
        test_broken_escapes();
        test_quote_errors();
        test_random_phase(0, 0);
        test_output_holdoff();
        test_drain_pause();
        test_random_phase(69, 0);
        test_random_phase(0, 69);
        test_random_phase(37, 37);
        s_valid  <= 1'b0;
        stall_pct = 0;
        while (expected_tokens.size() != 0) @(posedge aclk);
        repeat (10) @(posedge aclk);
        if (errors == 0) begin
            $display("PASS");
        end else begin
            $display("FAIL");
        end
        $finish;
    end

endmodule
